// ===== rtl/core/mclp_pkg.sv =====
// Shared types, constants and helpers for the motor command line parser.
package mclp_pkg;

  localparam int DEF_BUFFER_DEPTH = 16;
  localparam int MATCH_LEN        = 16;
  localparam int MATCH_IDX_W      = 4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam int ANGLE_MUL  = 96;
  localparam int ANGLE_DIV  = 999;
  localparam int PERIOD_NUM = 625 * 10;
  localparam int STEP_MAX_COUNT = 11;
  localparam int RPS_MAX_COUNT  = 9;

  localparam int ACC_W      = 14;
  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W  = 10;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_EVAL   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_DIR_CW    = 3'd1,
    CMD_DIR_CCW   = 3'd2,
    CMD_MOTOR_ON  = 3'd3,
    CMD_MOTOR_OFF = 3'd4,
    CMD_STEP_CW   = 3'd5,
    CMD_TEMP      = 3'd6,
    CMD_RPS       = 3'd7
  } cmd_t;

  typedef logic [MATCH_LEN-1:0][7:0] line_t;

  typedef struct packed {
    logic                  go;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // buffer position of digit idx for a numeric command
  function automatic logic [MATCH_IDX_W-1:0] digit_pos(cmd_t code, logic [1:0] idx);
    logic [MATCH_IDX_W-1:0] p;
    p = '0;
    case (code)
      CMD_STEP_CW: p = MATCH_IDX_W'(7) + MATCH_IDX_W'(idx);
      CMD_TEMP:    p = (idx == 2'd3) ? MATCH_IDX_W'(14) : MATCH_IDX_W'(10) + MATCH_IDX_W'(idx);
      CMD_RPS:     p = (idx == 2'd2) ? MATCH_IDX_W'(7) : MATCH_IDX_W'(4) + MATCH_IDX_W'(idx);
      default:     p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] digit_last(cmd_t code);
    return (code == CMD_TEMP) ? 2'd3 : 2'd2;
  endfunction

endpackage

// ===== rtl/core/mclp_match.sv =====
// Command pattern classifier over the first sixteen buffer bytes.
module mclp_match #(
  parameter int CNT_W = 4
) (
  input  mclp_pkg::line_t  line,
  input  logic [CNT_W-1:0] count,
  output mclp_pkg::cmd_t   code
);

  logic dir_c, motor_o, step_p, temp_p, rps_p;

  assign dir_c   = line[0] == "D" && line[1] == "I" && line[2] == "R" && line[3] == ":" &&
                   line[4] == "C";
  assign motor_o = line[0] == "M" && line[1] == "O" && line[2] == "T" && line[3] == "O" &&
                   line[4] == "R" && line[5] == ":" && line[6] == "O";
  assign step_p  = line[0] == "S" && line[1] == "T" && line[2] == "E" && line[3] == "P" &&
                   line[4] == "C" && line[5] == "W" && line[6] == ":" && line[10] == 8'h00 &&
                   count < CNT_W'(mclp_pkg::STEP_MAX_COUNT);
  assign temp_p  = line[0] == "T" && line[1] == "E" && line[2] == "M" && line[3] == "P" &&
                   line[4] == "L" && line[5] == "I" && line[6] == "M" && line[7] == "I" &&
                   line[8] == "T" && line[9] == ":" && line[15] == 8'h00;
  assign rps_p   = line[0] == "R" && line[1] == "P" && line[2] == "S" && line[3] == ":" &&
                   line[6] == mclp_pkg::DOT_CHAR && line[8] == 8'h00 &&
                   count < CNT_W'(mclp_pkg::RPS_MAX_COUNT);

  always_comb begin
    code = mclp_pkg::CMD_NONE;
    if (dir_c) begin
      if (line[5] == "W" && line[6] == 8'h00) begin
        code = mclp_pkg::CMD_DIR_CW;
      end else if (line[5] == "C" && line[6] == "W") begin
        code = mclp_pkg::CMD_DIR_CCW;
      end
    end else if (motor_o) begin
      if (line[7] == "N" && line[8] == 8'h00) begin
        code = mclp_pkg::CMD_MOTOR_ON;
      end else if (line[7] == "F" && line[8] == "F" && line[9] == 8'h00) begin
        code = mclp_pkg::CMD_MOTOR_OFF;
      end
    end else if (step_p) begin
      code = mclp_pkg::CMD_STEP_CW;
    end else if (temp_p) begin
      code = mclp_pkg::CMD_TEMP;
    end else if (rps_p) begin
      code = mclp_pkg::CMD_RPS;
    end
  end

endmodule

// ===== rtl/core/mclp_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module mclp_div (
  input  logic               clk,
  input  logic               rst,
  input  mclp_pkg::div_req_t req,
  output mclp_pkg::div_rsp_t rsp
);

  localparam int DW = mclp_pkg::DIVIDEND_W;
  localparam int VW = mclp_pkg::DIVISOR_W;
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] count;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] divisor;
  logic          done;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        count <= CW'(DW);
      end else if (count != '0) begin
        count <= count - 1'b1;
        done  <= count == CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (count != '0) begin
      rem <= fits ? VW'(trial - {1'b0, divisor}) : VW'(trial);
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/core/motor_command_line_parser_top.sv =====
// Motor command line parser: line buffer, digit sequencer and shared divider.
// Append and clear beats complete on acceptance and never raise busy. An evaluate beat
// raises busy and returns one result strobed on done for one cycle. Commands
// without a number go straight from idle to done. TEMPLIMIT, STEPCW and RPS first
// take one digit per step in the digit accumulator, then a setup step. TEMPLIMIT and
// STEPCW or RPS with a bad digit or a zero speed then go to done. Otherwise
// seventeen quotient steps follow in the serial divider, and done follows its
// done pulse. The result cannot be held off; the next beat may start in the cycle
// after done.
module motor_command_line_parser_top #(
  parameter int BUFFER_DEPTH = mclp_pkg::DEF_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_in,
  output logic        done,
  output logic [2:0]  command_code,
  output logic [6:0]  step_angle,
  output logic [12:0] speed_period,
  output logic [13:0] temp_limit_value,
  output logic        number_error
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH);
  localparam int AW    = mclp_pkg::ACC_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIGIT = 5'b00010,
    S_SETUP = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state;
  mclp_pkg::line_t    line;
  logic [CNT_W-1:0]   char_count;
  logic               buffer_full;
  mclp_pkg::cmd_t     match_code;
  mclp_pkg::cmd_t     code;
  logic [1:0]         idx;
  logic [AW-1:0]      acc;
  logic [AW-1:0]      acc_next;
  logic               bad;
  logic               accept;
  logic [7:0]         ch;
  logic               is_digit;
  logic [3:0]         dval;
  logic               div_ok;
  mclp_pkg::div_req_t div_req;
  mclp_pkg::div_rsp_t div_rsp;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;
  assign done   = state == S_DONE;

  mclp_match #(.CNT_W(CNT_W)) u_match (
    .line  (line),
    .count (char_count),
    .code  (match_code)
  );

  mclp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // line buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      line        <= '0;
      char_count  <= '0;
      buffer_full <= 1'b0;
    end else if (accept) begin
      if (opcode == mclp_pkg::OP_APPEND && !buffer_full) begin
        if ((char_count >> mclp_pkg::MATCH_IDX_W) == '0) begin
          line[char_count[mclp_pkg::MATCH_IDX_W-1:0]] <= char_in;
        end
        char_count  <= char_count + 1'b1;
        buffer_full <= char_count == CNT_W'(BUFFER_DEPTH - 2);
      end else if (opcode == mclp_pkg::OP_CLEAR) begin
        line        <= '0;
        char_count  <= '0;
        buffer_full <= 1'b0;
      end
    end
  end

  assign ch       = line[mclp_pkg::digit_pos(code, idx)];
  assign is_digit = ch >= mclp_pkg::ASCII_ZERO && ch <= mclp_pkg::ASCII_NINE;
  assign dval     = is_digit ? 4'(ch - mclp_pkg::ASCII_ZERO) : 4'd0;
  assign acc_next = AW'((acc << 3) + (acc << 1) + AW'(dval));

  assign div_ok = !bad && (code == mclp_pkg::CMD_STEP_CW ||
                           (code == mclp_pkg::CMD_RPS && acc != '0));

  always_comb begin
    div_req.go       = state == S_SETUP && div_ok;
    div_req.dividend = mclp_pkg::DIVIDEND_W'(mclp_pkg::PERIOD_NUM);
    div_req.divisor  = acc[mclp_pkg::DIVISOR_W-1:0];
    if (code == mclp_pkg::CMD_STEP_CW) begin
      div_req.dividend = mclp_pkg::DIVIDEND_W'(acc) * mclp_pkg::DIVIDEND_W'(mclp_pkg::ANGLE_MUL);
      div_req.divisor  = mclp_pkg::DIVISOR_W'(mclp_pkg::ANGLE_DIV);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= mclp_pkg::CMD_NONE;
      idx   <= '0;
      acc   <= '0;
      bad   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && opcode == mclp_pkg::OP_EVAL) begin
            code  <= match_code;
            idx   <= '0;
            acc   <= '0;
            bad   <= 1'b0;
            state <= (match_code == mclp_pkg::CMD_STEP_CW || match_code == mclp_pkg::CMD_TEMP ||
                      match_code == mclp_pkg::CMD_RPS) ? S_DIGIT : S_DONE;
          end
        end
        S_DIGIT: begin
          acc <= acc_next;
          bad <= bad || !is_digit;
          idx <= idx + 1'b1;
          if (idx == mclp_pkg::digit_last(code)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (code == mclp_pkg::CMD_RPS && acc == '0) begin
            bad <= 1'b1;
          end
          state <= div_ok ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign command_code     = code;
  assign number_error     = bad;
  assign step_angle       = (code == mclp_pkg::CMD_STEP_CW && !bad) ? div_rsp.quotient[6:0] : '0;
  assign speed_period     = (code == mclp_pkg::CMD_RPS && !bad) ? div_rsp.quotient[12:0] : '0;
  assign temp_limit_value = (code == mclp_pkg::CMD_TEMP && !bad) ? acc : '0;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after result beat");
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == mclp_pkg::OP_EVAL) |=> busy)
    else $error("evaluate beat did not raise busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_W'(BUFFER_DEPTH - 1))
    else $error("character count past limit");
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (done && number_error) |-> (code == mclp_pkg::CMD_STEP_CW || code == mclp_pkg::CMD_TEMP ||
                                code == mclp_pkg::CMD_RPS))
    else $error("number error on a command without a number");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside divide state");

endmodule

// ===== verif/tb_motor_command_line_parser_top.sv =====
// Self-checking testbench for the motor command line parser: directed lines, then random beats.
module tb_motor_command_line_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = mclp_pkg::DEF_BUFFER_DEPTH;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_BEATS = 570;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    mclp_pkg::cmd_t code;
    logic [6:0]     angle;
    logic [12:0]    period;
    logic [13:0]    temp;
    logic           err;
  } parse_result_t;

  typedef struct {
    string         text;
    bit            pinned;
    parse_result_t res;
  } line_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = mclp_pkg::OP_APPEND;
  logic [7:0] char_in = 8'h00;
  logic busy;
  logic done;
  logic [2:0] command_code;
  logic [6:0] step_angle;
  logic [12:0] speed_period;
  logic [13:0] temp_limit_value;
  logic number_error;

  logic [7:0] line_buf [DEPTH];
  int line_len;
  bit line_full;

  parse_result_t pending_results [$];
  bit pinned_pending;
  parse_result_t pinned_res;
  int mismatch_count;
  int beats_sent;
  int idle_pct;
  logic [7:0] line_q [$];
  line_case_t line_cases [];

  motor_command_line_parser_top #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .char_in(char_in),
    .done(done),
    .command_code(command_code),
    .step_angle(step_angle),
    .speed_period(speed_period),
    .temp_limit_value(temp_limit_value),
    .number_error(number_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] char_at(int pos);
    return (pos < DEPTH) ? line_buf[pos] : 8'h00;
  endfunction

  function automatic bit has_prefix(string pat);
    for (int i = 0; i < pat.len(); i++) begin
      if (char_at(i) != pat[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // -1 marks a position without an ASCII digit
  function automatic int digit_val(int pos);
    logic [7:0] c;
    c = char_at(pos);
    if (c < mclp_pkg::ASCII_ZERO || c > mclp_pkg::ASCII_NINE) return -1;
    return int'(c - mclp_pkg::ASCII_ZERO);
  endfunction

  function automatic mclp_pkg::cmd_t match_command();
    if (has_prefix("DIR:C")) begin
      if (char_at(5) == "W" && char_at(6) == 8'h00) return mclp_pkg::CMD_DIR_CW;
      if (char_at(5) == "C" && char_at(6) == "W") return mclp_pkg::CMD_DIR_CCW;
      return mclp_pkg::CMD_NONE;
    end
    if (has_prefix("MOTOR:O")) begin
      if (char_at(7) == "N" && char_at(8) == 8'h00) return mclp_pkg::CMD_MOTOR_ON;
      if (char_at(7) == "F" && char_at(8) == "F" && char_at(9) == 8'h00)
        return mclp_pkg::CMD_MOTOR_OFF;
      return mclp_pkg::CMD_NONE;
    end
    if (has_prefix("STEPCW:") && char_at(10) == 8'h00 &&
        line_len < mclp_pkg::STEP_MAX_COUNT)
      return mclp_pkg::CMD_STEP_CW;
    if (has_prefix("TEMPLIMIT:") && char_at(15) == 8'h00) return mclp_pkg::CMD_TEMP;
    if (has_prefix("RPS:") && char_at(6) == mclp_pkg::DOT_CHAR && char_at(8) == 8'h00 &&
        line_len < mclp_pkg::RPS_MAX_COUNT)
      return mclp_pkg::CMD_RPS;
    return mclp_pkg::CMD_NONE;
  endfunction

  function automatic parse_result_t parse_line();
    parse_result_t r;
    int d0, d1, d2, d3, v;
    bit bad;
    r = '0;
    r.code = match_command();
    bad = 1'b0;
    case (r.code)
      mclp_pkg::CMD_STEP_CW: begin
        d0 = digit_val(7); d1 = digit_val(8); d2 = digit_val(9);
        bad = (d0 < 0) || (d1 < 0) || (d2 < 0);
        v = 100 * d0 + 10 * d1 + d2;
        if (!bad) r.angle = 7'((v * mclp_pkg::ANGLE_MUL) / mclp_pkg::ANGLE_DIV);
      end
      mclp_pkg::CMD_TEMP: begin
        d0 = digit_val(10); d1 = digit_val(11); d2 = digit_val(12); d3 = digit_val(14);
        bad = (d0 < 0) || (d1 < 0) || (d2 < 0) || (d3 < 0);
        v = 1000 * d0 + 100 * d1 + 10 * d2 + d3;
        if (!bad) r.temp = 14'(v);
      end
      mclp_pkg::CMD_RPS: begin
        d0 = digit_val(4); d1 = digit_val(5); d2 = digit_val(7);
        bad = (d0 < 0) || (d1 < 0) || (d2 < 0);
        v = 100 * d0 + 10 * d1 + d2;
        if (v == 0) bad = 1'b1;
        if (!bad) r.period = 13'(mclp_pkg::PERIOD_NUM / v);
      end
      default: ;
    endcase
    r.err = bad;
    return r;
  endfunction

  task automatic record_beat(logic [1:0] op, logic [7:0] ch);
    case (op)
      mclp_pkg::OP_APPEND: begin
        if (!line_full && line_len < DEPTH) begin
          line_buf[line_len] = ch;
          line_len++;
        end
        if (line_len >= DEPTH - 1) line_full = 1'b1;
      end
      mclp_pkg::OP_CLEAR: begin
        foreach (line_buf[i]) line_buf[i] = 8'h00;
        line_len = 0;
        line_full = 1'b0;
      end
      mclp_pkg::OP_EVAL: begin
        pending_results.push_back(pinned_pending ? pinned_res : parse_line());
        pinned_pending = 1'b0;
      end
      default: ;
    endcase
    if (op != OP_UNUSED) beats_sent++;
  endtask

  task automatic send_beat(logic [1:0] op, logic [7:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    char_in <= ch;
    do @(posedge clk); while (busy);
    record_beat(op, ch);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  // mostly digits, zero-heavy, with the odd neighbor of the digit range or junk
  function automatic void add_digit();
    int r;
    r = $urandom_range(15);
    if (r == 0) line_q.push_back(8'($urandom_range(255)));
    else if (r == 1) line_q.push_back($urandom_range(1) ? 8'h2F : 8'h3A);
    else if (r < 6) line_q.push_back(mclp_pkg::ASCII_ZERO);
    else line_q.push_back(mclp_pkg::ASCII_ZERO + 8'($urandom_range(9)));
  endfunction

  task automatic send_random_line();
    line_q.delete();
    case ($urandom_range(7))
      0: add_text("DIR:CW");
      1: add_text("DIR:CCW");
      2: add_text("MOTOR:ON");
      3: add_text("MOTOR:OFF");
      4: begin
        add_text("STEPCW:");
        repeat (3) add_digit();
      end
      5: begin
        add_text("TEMPLIMIT:");
        repeat (3) add_digit();
        line_q.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) :
                         mclp_pkg::DOT_CHAR);
        add_digit();
      end
      6: begin
        add_text("RPS:");
        repeat (2) add_digit();
        line_q.push_back(mclp_pkg::DOT_CHAR);
        add_digit();
      end
      default: repeat ($urandom_range(20)) line_q.push_back(8'($urandom_range(255)));
    endcase
    if ($urandom_range(7) == 0 && line_q.size() > 0)
      line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(8'h20, 8'h5A)));
    if ($urandom_range(9) == 0 && line_q.size() > 0) void'(line_q.pop_back());

    if ($urandom_range(9) != 0) send_beat(mclp_pkg::OP_CLEAR, 8'($urandom_range(255)));
    foreach (line_q[i]) send_beat(mclp_pkg::OP_APPEND, line_q[i]);
    if ($urandom_range(19) == 0) send_beat(OP_UNUSED, 8'($urandom_range(255)));
    send_beat(mclp_pkg::OP_EVAL, 8'($urandom_range(255)));
    if ($urandom_range(14) == 0) send_beat(mclp_pkg::OP_EVAL, 8'($urandom_range(255)));
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    parse_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, command_code %0d", $time, command_code);
        mismatch_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("command_code", e.code, command_code);
        check_field("step_angle", e.angle, step_angle);
        check_field("speed_period", e.period, speed_period);
        check_field("temp_limit_value", e.temp, temp_limit_value);
        check_field("number_error", e.err, number_error);
      end
    end
  end

  initial begin
    int phase_end;
    int idle_set [3];
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    line_len = 0;
    line_full = 1'b0;
    pinned_pending = 1'b0;
    pinned_res = '0;
    mismatch_count = 0;
    beats_sent = 0;
    idle_pct = 0;
    idle_set = '{0, 53, 23};
    line_cases = '{
      '{"", 1'b1, '{mclp_pkg::CMD_NONE, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"DIR:CW", 1'b1, '{mclp_pkg::CMD_DIR_CW, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"DIR:CCW", 1'b1, '{mclp_pkg::CMD_DIR_CCW, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"DIR:CWX", 1'b1, '{mclp_pkg::CMD_NONE, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"MOTOR:ON", 1'b1, '{mclp_pkg::CMD_MOTOR_ON, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"MOTOR:OFF", 1'b1, '{mclp_pkg::CMD_MOTOR_OFF, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"MOTOR:OX", 1'b1, '{mclp_pkg::CMD_NONE, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"MOTOR:OFFX", 1'b1, '{mclp_pkg::CMD_NONE, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"STEPCW:999", 1'b1, '{mclp_pkg::CMD_STEP_CW, 7'd96, 13'd0, 14'd0, 1'b0}},
      '{"STEPCW:000", 1'b1, '{mclp_pkg::CMD_STEP_CW, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"STEPCW:5A7", 1'b1, '{mclp_pkg::CMD_STEP_CW, 7'd0, 13'd0, 14'd0, 1'b1}},
      '{"STEPCW:123", 1'b0, '0},
      '{"STEPCW:1234", 1'b1, '{mclp_pkg::CMD_NONE, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"STEPCW:12345678901234567", 1'b0, '0},
      '{"TEMPLIMIT:999x9", 1'b1, '{mclp_pkg::CMD_TEMP, 7'd0, 13'd0, 14'd9999, 1'b0}},
      '{"TEMPLIMIT:000.0", 1'b1, '{mclp_pkg::CMD_TEMP, 7'd0, 13'd0, 14'd0, 1'b0}},
      '{"TEMPLIMIT:12/.4", 1'b1, '{mclp_pkg::CMD_TEMP, 7'd0, 13'd0, 14'd0, 1'b1}},
      '{"TEMPLIMIT:12345678", 1'b0, '0},
      '{"RPS:00.1", 1'b1, '{mclp_pkg::CMD_RPS, 7'd0, 13'd6250, 14'd0, 1'b0}},
      '{"RPS:00.0", 1'b1, '{mclp_pkg::CMD_RPS, 7'd0, 13'd0, 14'd0, 1'b1}},
      '{"RPS:99.9", 1'b1, '{mclp_pkg::CMD_RPS, 7'd0, 13'd6, 14'd0, 1'b0}},
      '{"RPS:12.:", 1'b1, '{mclp_pkg::CMD_RPS, 7'd0, 13'd0, 14'd0, 1'b1}},
      '{"RPS:37.5", 1'b0, '0},
      '{"RPS:12.34", 1'b1, '{mclp_pkg::CMD_NONE, 7'd0, 13'd0, 14'd0, 1'b0}}
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // first row evaluates the reset buffer without a clear
    foreach (line_cases[i]) begin
      if (i != 0) send_beat(mclp_pkg::OP_CLEAR, 8'($urandom_range(255)));
      for (int k = 0; k < line_cases[i].text.len(); k++)
        send_beat(mclp_pkg::OP_APPEND, line_cases[i].text[k]);
      pinned_pending = line_cases[i].pinned;
      pinned_res = line_cases[i].res;
      send_beat(mclp_pkg::OP_EVAL, 8'($urandom_range(255)));
    end
    send_beat(mclp_pkg::OP_CLEAR, 8'hFF);
    send_beat(mclp_pkg::OP_APPEND, 8'hFF);
    send_beat(mclp_pkg::OP_APPEND, 8'h00);
    send_beat(OP_UNUSED, 8'hAA);
    send_beat(mclp_pkg::OP_EVAL, 8'h00);
    send_beat(mclp_pkg::OP_EVAL, 8'h55);

    foreach (idle_set[p]) begin
      idle_pct = idle_set[p];
      if (p == 1) drain();
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        send_random_line();
        if ($urandom_range(39) == 0) drain();
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
